>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the Targa RLE pixel decoder.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tga_rle_pkg.sv
// Shared types and constants for the Targa RLE pixel decoder.
// No dependencies; imported by tga_rle_palette and tga_rle_pixel_decoder.
package tga_rle_pkg;

  localparam int COLOR_W       = 24;
  localparam int CNT_W         = 16;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 32;
  localparam int OUT_TUSER_W   = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int PAL_DEPTH_DEF = 256;

  // request kinds (in_tuser)
  localparam logic CMD_PIXEL_BYTE = 1'b0;
  localparam logic CMD_PAL_WRITE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd3;

  // color modes; the remaining codes decode as grayscale
  localparam logic [1:0] MODE_PALETTE   = 2'd0;
  localparam logic [1:0] MODE_TRUECOLOR = 2'd1;

  // truecolor byte order within one pixel
  localparam logic [1:0] BP_BLUE  = 2'd0;
  localparam logic [1:0] BP_GREEN = 2'd1;
  localparam logic [1:0] BP_RED   = 2'd2;

  // decoded pixel waiting for the palette read
  typedef struct packed {
    logic               pal;
    logic               pal_ok;
    logic [COLOR_W-1:0] rgb;
    logic [7:0]         repeat_count;
    logic               row_end;
    logic               image_end;
    logic               overrun;
  } pix_info_t;

endpackage

>>> design/tga_rle_palette.sv
// Palette RAM: one write port, one read port with registered read data.
// Depends on tga_rle_pkg (color width, default depth).
module tga_rle_palette
  import tga_rle_pkg::*;
#(
  parameter int DEPTH = PAL_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] palette_mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= palette_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/tga_rle_pixel_decoder.sv
// Targa RLE pixel decoder top level: packet/column control, output pipeline.
// Depends on tga_rle_pkg, tga_rle_palette and assert_macros.svh.
`include "assert_macros.svh"

// Takes one byte request per clock and emits RGB pixels on the out_ stream.
// Each request is either a pixel-stream byte (in_tuser = 0) or a palette
// entry write (in_tuser = 1); palette writes and packet headers give no
// output. The block sustains one request per cycle with no bubbles while
// out_tready is high; once its last byte is taken, a pixel passes the palette
// RAM's registered read (s1) and then the output register. The path is
// accept (packet, byte and column tracking, palette read issued) -> s1
// (palette data returns) -> output register. Backpressure on out_tready
// stalls s1 and then the input; the palette read data is held meanwhile.
// With RLE on, a run packet gives a single pixel with repeat_count set; a
// packet that runs past the row end is clipped there and flagged in
// out_tuser[1]. out_tlast marks the pixel that ends a row and out_tuser[0]
// the one that ends the image. Width or height of zero acts as one.
// Registers (cfg_index): 0 color_mode, 1 rle_enable, 2 pixels per row,
// 3 rows per image; write them only while no pixel is in flight.
module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
#(
  parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte, palette_index, palette_color
  input  logic                   in_tuser,   // command
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // red, green, blue, repeat_count
  output logic                   out_tlast,  // row_end
  output logic [OUT_TUSER_W-1:0] out_tuser,  // image_end, packet_overrun
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // packet phase codes
  localparam logic PKT_HEADER = 1'b0;
  localparam logic PKT_BODY   = 1'b1;

  // request fields
  logic               in_cmd;
  logic [7:0]         in_byte;
  logic [7:0]         in_pidx;
  logic [COLOR_W-1:0] in_pcolor;

  assign in_cmd    = in_tuser;
  assign in_byte   = in_tdata[7:0];
  assign in_pidx   = in_tdata[15:8];
  assign in_pcolor = in_tdata[39:16];

  // configuration registers
  logic [1:0]       color_mode_r;
  logic             rle_enable_r;
  logic [CNT_W-1:0] row_width_r;
  logic [CNT_W-1:0] frame_rows_r;

  // decode state
  logic               packet_phase_r,  packet_phase_nxt;
  logic [7:0]         packet_left_r,   packet_left_nxt;
  logic               packet_is_run_r, packet_is_run_nxt;
  logic [1:0]         byte_phase_r,    byte_phase_nxt;
  logic [15:0]        partial_color_r, partial_color_nxt;
  logic [CNT_W-1:0]   column_count_r,  column_count_nxt;
  logic [CNT_W-1:0]   row_count_r,     row_count_nxt;

  // pipeline
  logic               s1_v_r;
  pix_info_t          s1_info_r;
  pix_info_t          pix_nxt;
  logic               out_v_r;
  logic [COLOR_W-1:0] out_rgb_r;
  logic [7:0]         out_repeat_r;
  logic               out_row_end_r;
  logic               out_img_end_r;
  logic               out_ovr_r;
  logic               s1_go;

  // step logic
  logic               acc;
  logic               data_acc;
  logic               pidx_ok;
  logic               byte_ok;
  logic               pix_fire;
  logic [CNT_W-1:0]   w_eff;
  logic [CNT_W-1:0]   h_eff;
  logic [CNT_W-1:0]   rem;
  logic [7:0]         left_dec;
  logic [CNT_W-1:0]   row_inc;
  logic [COLOR_W-1:0] pal_rd_data;
  logic [COLOR_W-1:0] s1_rgb;

  assign s1_go     = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_go;
  assign acc       = in_tvalid && in_tready;
  assign data_acc  = acc && (in_cmd == CMD_PIXEL_BYTE);

  assign pidx_ok = {1'b0, in_pidx} < 9'(PALETTE_DEPTH);
  assign byte_ok = {1'b0, in_byte} < 9'(PALETTE_DEPTH);

  assign w_eff    = (row_width_r == '0) ? CNT_W'(1) : row_width_r;
  assign h_eff    = (frame_rows_r == '0) ? CNT_W'(1) : frame_rows_r;
  // pixels left in the row; a column past the end counts as one left
  assign rem      = (column_count_r < w_eff) ? (w_eff - column_count_r) : CNT_W'(1);
  assign left_dec = packet_left_r - 8'd1;
  assign row_inc  = row_count_r + CNT_W'(1);

  always_comb begin
    packet_phase_nxt     = packet_phase_r;
    packet_left_nxt      = packet_left_r;
    packet_is_run_nxt    = packet_is_run_r;
    byte_phase_nxt       = byte_phase_r;
    partial_color_nxt    = partial_color_r;
    column_count_nxt     = column_count_r;
    row_count_nxt        = row_count_r;
    pix_fire             = 1'b0;
    pix_nxt.pal          = 1'b0;
    pix_nxt.pal_ok       = byte_ok;
    pix_nxt.rgb          = '0;
    pix_nxt.repeat_count = 8'd1;
    pix_nxt.row_end      = 1'b0;
    pix_nxt.image_end    = 1'b0;
    pix_nxt.overrun      = 1'b0;

    if (data_acc) begin
      if (rle_enable_r && (packet_phase_r == PKT_HEADER)) begin
        packet_left_nxt   = {1'b0, in_byte[6:0]} + 8'd1;
        packet_is_run_nxt = in_byte[7];
        packet_phase_nxt  = PKT_BODY;
        byte_phase_nxt    = BP_BLUE;
        partial_color_nxt = '0;
      end else begin
        case (color_mode_r)
          MODE_PALETTE: begin
            pix_fire       = 1'b1;
            pix_nxt.pal    = 1'b1;
            byte_phase_nxt = BP_BLUE;
          end
          MODE_TRUECOLOR: begin
            case (byte_phase_r)
              BP_BLUE: begin
                partial_color_nxt = {8'h00, in_byte};
                byte_phase_nxt    = BP_GREEN;
              end
              BP_GREEN: begin
                partial_color_nxt = {in_byte, partial_color_r[7:0]};
                byte_phase_nxt    = BP_RED;
              end
              default: begin
                pix_fire          = 1'b1;
                pix_nxt.rgb       = {in_byte, partial_color_r};
                byte_phase_nxt    = BP_BLUE;
                partial_color_nxt = '0;
              end
            endcase
          end
          default: begin
            // grayscale, also the unused mode code
            pix_fire       = 1'b1;
            pix_nxt.rgb    = {in_byte, in_byte, in_byte};
            byte_phase_nxt = BP_BLUE;
          end
        endcase

        if (pix_fire) begin
          if (rle_enable_r) begin
            if (packet_is_run_r) begin
              if ({8'h00, packet_left_r} > rem) begin
                pix_nxt.repeat_count = rem[7:0];  // rem < 128 here
                pix_nxt.overrun      = 1'b1;
              end else begin
                pix_nxt.repeat_count = packet_left_r;
              end
              packet_left_nxt = '0;
            end else begin
              packet_left_nxt = left_dec;
              if ((rem == CNT_W'(1)) && (left_dec != '0)) begin
                pix_nxt.overrun = 1'b1;
                packet_left_nxt = '0;
              end
            end
            if (packet_left_nxt == '0) begin
              packet_phase_nxt = PKT_HEADER;
            end
          end

          column_count_nxt = column_count_r + {8'h00, pix_nxt.repeat_count};
          if ({8'h00, pix_nxt.repeat_count} >= rem) begin
            pix_nxt.row_end  = 1'b1;
            column_count_nxt = '0;
            row_count_nxt    = row_inc;
            if (row_inc >= h_eff) begin
              pix_nxt.image_end = 1'b1;
              row_count_nxt     = '0;
            end
          end
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_PALETTE;
      rle_enable_r <= 1'b0;
      row_width_r  <= CNT_W'(1);
      frame_rows_r <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode_r <= cfg_wdata[1:0];
        CFG_RLE_ENABLE: rle_enable_r <= cfg_wdata[0];
        CFG_ROW_PIXELS: row_width_r  <= cfg_wdata;
        CFG_IMAGE_ROWS: frame_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_phase_r  <= PKT_HEADER;
      packet_left_r   <= '0;
      packet_is_run_r <= 1'b0;
      byte_phase_r    <= BP_BLUE;
      partial_color_r <= '0;
      column_count_r  <= '0;
      row_count_r     <= '0;
    end else begin
      packet_phase_r  <= packet_phase_nxt;
      packet_left_r   <= packet_left_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      byte_phase_r    <= byte_phase_nxt;
      partial_color_r <= partial_color_nxt;
      column_count_r  <= column_count_nxt;
      row_count_r     <= row_count_nxt;
    end
  end

  // palette: written on palette requests, read for palette-mode pixels
  tga_rle_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (acc && (in_cmd == CMD_PAL_WRITE) && pidx_ok),
    .wr_addr (in_pidx[AW-1:0]),
    .wr_data (in_pcolor),
    .rd_en   (pix_fire && pix_nxt.pal),
    .rd_addr (in_byte[AW-1:0]),
    .rd_data (pal_rd_data)
  );

  // s1: waits for the palette data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && pix_fire) begin
      s1_info_r <= pix_nxt;
    end
  end

  // out-of-range index reads as black
  assign s1_rgb = s1_info_r.pal ? (s1_info_r.pal_ok ? pal_rd_data : '0) : s1_info_r.rgb;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_v_r) begin
      out_rgb_r     <= s1_rgb;
      out_repeat_r  <= s1_info_r.repeat_count;
      out_row_end_r <= s1_info_r.row_end;
      out_img_end_r <= s1_info_r.image_end;
      out_ovr_r     <= s1_info_r.overrun;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_repeat_r, out_rgb_r[7:0], out_rgb_r[15:8], out_rgb_r[23:16]};
  assign out_tlast  = out_row_end_r;
  assign out_tuser  = {out_ovr_r, out_img_end_r};

  `CHK_IMPLY(a_body_has_left, packet_phase_r == PKT_BODY, packet_left_r != '0, "empty packet")
  `CHK_IMPLY(a_img_end_row_end, s1_v_r && s1_info_r.image_end, s1_info_r.row_end, "image end")
  `CHK_IMPLY(a_ovr_row_end, out_v_r && out_ovr_r, out_row_end_r, "clip off row end")
  `CHK_IMPLY(a_repeat_nonzero, out_v_r, out_repeat_r != '0, "zero repeat count")
  `CHK_NEXT(a_rd_hold, s1_v_r && s1_info_r.pal && !s1_go, $stable(pal_rd_data), "read lost")

endmodule
